### rtl/tdi_pkg.sv
package tdi_pkg;

	localparam int unsigned XY_W   = 16;
	localparam int unsigned Z_W    = 32;
	localparam int unsigned FAR_W  = 31;
	localparam int unsigned DIF_W  = XY_W + 1;
	localparam int unsigned PRD_W  = 2 * DIF_W;
	localparam int unsigned DET_W  = PRD_W + 1;
	localparam int unsigned DG_W   = DET_W + 2;
	localparam int unsigned WZ_W   = DG_W + Z_W;
	localparam int unsigned NUM_W  = WZ_W + 2;
	localparam int unsigned DMAG_W = DET_W - 1;
	localparam int unsigned QB     = Z_W + 1;
	localparam int unsigned REM_W  = DMAG_W + 1;
	localparam int unsigned NDIV   = QB + 1;

	localparam logic [Z_W-1:0] DEPTH_MAX = 32'h7FFF_FFFF;
	localparam logic [Z_W-1:0] DEPTH_MIN = 32'h8000_0000;
	localparam logic [FAR_W-1:0] FAR_RESET = 31'h7FFF_FFFF;

	typedef struct packed {
		logic                   cmd;
		logic signed [XY_W-1:0] v0_x;
		logic signed [XY_W-1:0] v0_y;
		logic signed [Z_W-1:0]  v0_z;
		logic signed [XY_W-1:0] v1_x;
		logic signed [XY_W-1:0] v1_y;
		logic signed [Z_W-1:0]  v1_z;
		logic signed [XY_W-1:0] v2_x;
		logic signed [XY_W-1:0] v2_y;
		logic signed [Z_W-1:0]  v2_z;
		logic signed [XY_W-1:0] query_x;
		logic signed [XY_W-1:0] query_y;
	} item_t;

	typedef struct packed {
		logic signed [Z_W-1:0] depth;
		logic                  inside_res;
		logic                  degenerate;
	} result_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [QB-1:0]     low;
		logic [QB-1:0]     quo;
		logic [DMAG_W-1:0] dmag;
		logic              neg_q;
		logic              ovf;
		logic              in_tri;
		logic              degen;
		logic              reject;
	} div_t;

endpackage

### rtl/triangle_depth_interpolate.sv
// An accepted item passes stages s1 to s6, the divider stages and the output register in order.
// Throughput: one transaction per cycle while the skid register is empty; the 33 quotient
// bits come from a chain of 33 compare-subtract stages, one bit each.
// A full skid register at the output holds the whole pipeline until it drains.
// Reset (arst_n low, asynchronous) empties every stage and sets far_q to its maximum.
module triangle_depth_interpolate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  tdi_pkg::item_t              item_data,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tdi_pkg::result_t            result_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tdi_pkg::FAR_W-1:0]   cfg_data
);

	localparam int unsigned XW = tdi_pkg::DIF_W;
	localparam int unsigned PW = tdi_pkg::PRD_W;
	localparam int unsigned DW = tdi_pkg::DET_W;
	localparam int unsigned GW = tdi_pkg::DG_W;
	localparam int unsigned WW = tdi_pkg::WZ_W;
	localparam int unsigned NW = tdi_pkg::NUM_W;
	localparam int unsigned MW = tdi_pkg::DMAG_W;
	localparam int unsigned QB = tdi_pkg::QB;
	localparam int unsigned RW = tdi_pkg::REM_W;
	localparam int unsigned ZW = tdi_pkg::Z_W;
	localparam int unsigned ND = tdi_pkg::NDIV;

	logic [tdi_pkg::FAR_W-1:0] far_q;
	logic en;
	logic skid_v_q;
	tdi_pkg::result_t skid_q;

	assign cfg_ready = 1'b1;
	assign en = !skid_v_q;
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_q <= tdi_pkg::FAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			far_q <= cfg_data;
		end
	end

	// s1: edge differences
	logic v_s1;
	logic cmd_s1;
	logic signed [XW-1:0] a_s1, b_s1, c_s1, e_s1, f_s1, g_s1;
	logic signed [ZW-1:0] z0_s1, z1_s1, z2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= item_data.cmd;
			a_s1 <= XW'(item_data.v0_x) - XW'(item_data.v2_x);
			b_s1 <= XW'(item_data.v1_y) - XW'(item_data.v2_y);
			c_s1 <= XW'(item_data.v1_x) - XW'(item_data.v2_x);
			e_s1 <= XW'(item_data.v0_y) - XW'(item_data.v2_y);
			f_s1 <= XW'(item_data.query_x) - XW'(item_data.v2_x);
			g_s1 <= XW'(item_data.query_y) - XW'(item_data.v2_y);
			z0_s1 <= item_data.v0_z;
			z1_s1 <= item_data.v1_z;
			z2_s1 <= item_data.v2_z;
		end
	end

	// s2: cross products
	logic v_s2;
	logic cmd_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [ZW-1:0] z0_s2, z1_s2, z2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			p1_s2 <= PW'(a_s1) * PW'(b_s1);
			p2_s2 <= PW'(c_s1) * PW'(e_s1);
			p3_s2 <= PW'(f_s1) * PW'(b_s1);
			p4_s2 <= PW'(c_s1) * PW'(g_s1);
			p5_s2 <= PW'(a_s1) * PW'(g_s1);
			p6_s2 <= PW'(f_s1) * PW'(e_s1);
			z0_s2 <= z0_s1;
			z1_s2 <= z1_s1;
			z2_s2 <= z2_s1;
		end
	end

	// s3: determinants
	logic v_s3;
	logic cmd_s3;
	logic signed [DW-1:0] d_s3, da_s3, db_s3;
	logic signed [ZW-1:0] z0_s3, z1_s3, z2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			d_s3 <= DW'(p1_s2) - DW'(p2_s2);
			da_s3 <= DW'(p3_s2) - DW'(p4_s2);
			db_s3 <= DW'(p5_s2) - DW'(p6_s2);
			z0_s3 <= z0_s2;
			z1_s3 <= z1_s2;
			z2_s3 <= z2_s2;
		end
	end

	// s4: third weight, classification
	logic signed [GW-1:0] dg_c;
	logic in_c;

	always_comb begin
		dg_c = GW'(d_s3) - GW'(da_s3) - GW'(db_s3);
		if (d_s3 > 0) begin
			in_c = (da_s3 >= 0) && (db_s3 >= 0) && (dg_c >= 0);
		end else begin
			in_c = (da_s3 <= 0) && (db_s3 <= 0) && (dg_c <= 0);
		end
	end

	logic v_s4;
	logic inside_s4, degen_s4, reject_s4, dneg_s4;
	logic signed [GW-1:0] da_s4, db_s4, dg_s4;
	logic [MW-1:0] dmag_s4;
	logic signed [ZW-1:0] z0_s4, z1_s4, z2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s4 <= (d_s3 == '0);
			inside_s4 <= in_c && (d_s3 != '0);
			reject_s4 <= !cmd_s3 && !in_c;
			dneg_s4 <= d_s3[DW-1];
			dmag_s4 <= d_s3[DW-1] ? MW'(-d_s3) : MW'(d_s3);
			da_s4 <= GW'(da_s3);
			db_s4 <= GW'(db_s3);
			dg_s4 <= dg_c;
			z0_s4 <= z0_s3;
			z1_s4 <= z1_s3;
			z2_s4 <= z2_s3;
		end
	end

	// s5: weight times depth
	logic v_s5;
	logic inside_s5, degen_s5, reject_s5, dneg_s5;
	logic [MW-1:0] dmag_s5;
	logic signed [WW-1:0] w0_s5, w1_s5, w2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s5 <= inside_s4;
			degen_s5 <= degen_s4;
			reject_s5 <= reject_s4;
			dneg_s5 <= dneg_s4;
			dmag_s5 <= dmag_s4;
			w0_s5 <= WW'(da_s4) * WW'(z0_s4);
			w1_s5 <= WW'(db_s4) * WW'(z1_s4);
			w2_s5 <= WW'(dg_s4) * WW'(z2_s4);
		end
	end

	// s6: numerator magnitude and quotient sign
	logic signed [NW-1:0] num_c;

	assign num_c = NW'(w0_s5) + NW'(w1_s5) + NW'(w2_s5);

	logic v_s6;
	logic inside_s6, degen_s6, reject_s6, negq_s6;
	logic [MW-1:0] dmag_s6;
	logic [NW-1:0] mag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s6 <= inside_s5;
			degen_s6 <= degen_s5;
			reject_s6 <= reject_s5;
			negq_s6 <= num_c[NW-1] ^ dneg_s5;
			dmag_s6 <= dmag_s5;
			mag_s6 <= num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
		end
	end

	// divider: one setup stage then one quotient bit per stage
	logic v_div [ND];
	tdi_pkg::div_t div_s [ND];
	tdi_pkg::div_t div_init;

	always_comb begin
		div_init.ovf = (mag_s6[NW-1:QB] >= (NW-QB)'(dmag_s6));
		div_init.rem = RW'(mag_s6[NW-1:QB]);
		div_init.low = mag_s6[QB-1:0];
		div_init.quo = '0;
		div_init.dmag = dmag_s6;
		div_init.neg_q = negq_s6;
		div_init.in_tri = inside_s6;
		div_init.degen = degen_s6;
		div_init.reject = reject_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_div[0] <= 1'b0;
		end else if (en) begin
			v_div[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_init;
		end
	end

	for (genvar k = 1; k < ND; k++) begin : g_div
		logic [RW-1:0] trial;
		logic          take;
		tdi_pkg::div_t nxt;

		always_comb begin
			nxt = div_s[k-1];
			trial = {div_s[k-1].rem[RW-2:0], div_s[k-1].low[QB-1]};
			take = (trial >= RW'(div_s[k-1].dmag));
			nxt.rem = take ? trial - RW'(div_s[k-1].dmag) : trial;
			nxt.low = {div_s[k-1].low[QB-2:0], 1'b0};
			nxt.quo = {div_s[k-1].quo[QB-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div[k] <= 1'b0;
			end else if (en) begin
				v_div[k] <= v_div[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end
	end

	// output stage: saturation and selection
	tdi_pkg::div_t fin;
	tdi_pkg::result_t res_c;

	assign fin = div_s[ND-1];

	always_comb begin
		res_c.degenerate = fin.degen;
		res_c.inside_res = fin.in_tri;
		if (fin.degen) begin
			res_c.depth = '0;
		end else if (fin.reject) begin
			res_c.depth = -ZW'(far_q);
		end else if (fin.neg_q) begin
			if (fin.ovf || fin.quo > QB'(tdi_pkg::DEPTH_MIN)) begin
				res_c.depth = tdi_pkg::DEPTH_MIN;
			end else begin
				res_c.depth = -fin.quo[ZW-1:0];
			end
		end else begin
			if (fin.ovf || fin.quo > QB'(tdi_pkg::DEPTH_MAX)) begin
				res_c.depth = tdi_pkg::DEPTH_MAX;
			end else begin
				res_c.depth = fin.quo[ZW-1:0];
			end
		end
	end

	logic v_out_s;
	tdi_pkg::result_t out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_s <= 1'b0;
		end else if (en) begin
			v_out_s <= v_div[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= res_c;
		end
	end

	// skid: a stalled result parks here so one more transaction can move in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!result_stall) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_out_s && result_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && v_out_s && result_stall) begin
			skid_q <= out_s;
		end
	end

	assign result_valid = skid_v_q || v_out_s;
	assign result_data = skid_v_q ? skid_q : out_s;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.degenerate |->
			result_data.depth == '0 && !result_data.inside_res)
		else $error("degenerate result with non-zero depth or inside set");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !result_stall |=> !skid_v_q)
		else $error("skid register not drained after transaction");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(v_out_s) && $stable(out_s))
		else $error("pipeline moved while skid register full");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_v_q && v_out_s && result_stall |=> skid_v_q && skid_q == $past(out_s))
		else $error("stalled result not parked in skid register");

endmodule
